// ===== rtl/core/round_robin_ready_queue_defines.svh =====
// Assertion macros for the round-robin ready queue; they assume clk and rst_n in scope.
`ifndef ROUND_ROBIN_READY_QUEUE_DEFINES_SVH
`define ROUND_ROBIN_READY_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RRQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define RRQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rrq_pkg.sv =====
// Types and constants shared by the round-robin ready queue modules.
`timescale 1ns / 1ps

package rrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 8;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_NEXT    = 2'd2
    } rrq_cmd_e;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } rrq_status_e;

    typedef struct packed {
        logic [1:0]      command;
        logic [ID_W-1:0] process_id;
    } rrq_in_t;

    typedef struct packed {
        logic [ID_W-1:0] picked_id;
        logic [1:0]      status;
        logic [4:0]      occupancy;
    } rrq_out_t;

    // Broadcast controls from the top level to every cell
    typedef struct packed {
        logic             enq_wr;
        logic             deq_shift;
        logic [ID_W-1:0]  pid;
        logic [CNT_W-1:0] total;
        logic [IDX_W-1:0] cursor;
    } rrq_cell_ctl_t;

endpackage

// ===== rtl/core/rrq_cell.sv =====
// One queue slot: holds an id, compares it, and shifts down from its neighbor.
`timescale 1ns / 1ps

module rrq_cell (
    input  logic                        clk,
    input  logic [rrq_pkg::IDX_W-1:0]   index,
    input  rrq_pkg::rrq_cell_ctl_t      ctl,
    input  logic [rrq_pkg::ID_W-1:0]    nbr_id,
    input  logic                        hit_in,
    output logic                        hit_out,
    output logic                        first_hit,
    input  logic [rrq_pkg::ID_W-1:0]    pick_in,
    output logic [rrq_pkg::ID_W-1:0]    pick_out,
    output logic [rrq_pkg::ID_W-1:0]    id
);
    import rrq_pkg::*;

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            occupied;
    logic            match;

    // Compare against the searched id; pass the running hit down the row
    always_comb
    begin
        occupied  = ({1'b0, index} < ctl.total);
        match     = occupied && (id_reg == ctl.pid);
        hit_out   = hit_in | match;
        first_hit = match & ~hit_in;
        pick_out  = pick_in | ((index == ctl.cursor) ? id_reg : '0);
        id        = id_reg;
    end

    // Take the neighbor's id from the removed entry onward, or load an appended id
    always_comb
    begin
        id_next = id_reg;
        if (ctl.deq_shift && (hit_in || match))
        begin
            id_next = nbr_id;
        end
        else if (ctl.enq_wr && ({1'b0, index} == ctl.total))
        begin
            id_next = ctl.pid;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

// ===== rtl/core/round_robin_ready_queue.sv =====
// Slots compare and shift in parallel; an accepted command's result is registered.
// Throughput: one command per cycle unless out_ready stalls a pending result.
// The first-match search and cursor read ripple through the row of 16 slot cells.
// Reset (rst_n low, asynchronous): queue empty, cursor at slot 0, no result pending.
// Slot contents are not cleared; slots at or above the fill count are never read.
`timescale 1ns / 1ps

module round_robin_ready_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rrq_pkg::rrq_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rrq_pkg::rrq_out_t out_data
);
    import rrq_pkg::*;

    `include "round_robin_ready_queue_defines.svh"

    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [IDX_W-1:0] cursor_reg;
    logic [IDX_W-1:0] cursor_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    rrq_out_t         out_data_reg;
    rrq_out_t         out_data_next;

    rrq_cell_ctl_t    ctl;
    logic             accept;
    logic             full;
    logic             hit;
    logic [IDX_W-1:0] found_idx;
    logic [CNT_W-1:0] total_dec;
    logic [IDX_W:0]   cursor_inc;

    logic [QUEUE_DEPTH:0]   hit_chain;
    logic [QUEUE_DEPTH-1:0] first_vec;
    logic [ID_W-1:0]        pick_chain [QUEUE_DEPTH+1];
    logic [ID_W-1:0]        cell_id    [QUEUE_DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign full          = (total_reg == CNT_W'(QUEUE_DEPTH));
    assign hit           = hit_chain[QUEUE_DEPTH];
    assign hit_chain[0]  = 1'b0;
    assign pick_chain[0] = '0;

    // Drive the broadcast controls for the slot row
    always_comb
    begin
        ctl.pid       = in_data.process_id;
        ctl.total     = total_reg;
        ctl.cursor    = cursor_reg;
        ctl.enq_wr    = accept && (in_data.command == CMD_ENQUEUE) && !full;
        ctl.deq_shift = accept && (in_data.command == CMD_DEQUEUE) && hit;
    end

    // Row of slot cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] nbr;
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = cell_id[i+1];
        end

        rrq_cell u_cell (
            .clk       (clk),
            .index     (IDX_W'(i)),
            .ctl       (ctl),
            .nbr_id    (nbr),
            .hit_in    (hit_chain[i]),
            .hit_out   (hit_chain[i+1]),
            .first_hit (first_vec[i]),
            .pick_in   (pick_chain[i]),
            .pick_out  (pick_chain[i+1]),
            .id        (cell_id[i])
        );
    end

    // Encode the one-hot first match into a slot index
    always_comb
    begin
        found_idx = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            found_idx = found_idx | (first_vec[i] ? IDX_W'(i) : '0);
        end
    end

    assign total_dec  = total_reg - CNT_W'(1);
    assign cursor_inc = {1'b0, cursor_reg} + (IDX_W+1)'(1);

    // Decode the command: next state and result
    always_comb
    begin
        total_next     = total_reg;
        cursor_next    = cursor_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            out_data_next.picked_id = '0;
            out_data_next.status    = ST_OK;
            unique case (rrq_cmd_e'(in_data.command))
                CMD_ENQUEUE:
                begin
                    if (full)
                    begin
                        out_data_next.status = ST_FULL;
                    end
                    else
                    begin
                        total_next = total_reg + CNT_W'(1);
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (!hit)
                    begin
                        out_data_next.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        total_next = total_dec;
                        priority if (total_dec == '0)
                        begin
                            cursor_next = '0;
                        end
                        else if (cursor_reg == found_idx)
                        begin
                            if ({1'b0, found_idx} >= total_dec)
                            begin
                                cursor_next = '0;
                            end
                        end
                        else if (cursor_reg > found_idx)
                        begin
                            cursor_next = cursor_reg - IDX_W'(1);
                        end
                        else
                        begin
                            cursor_next = cursor_reg;
                        end
                    end
                end
                CMD_NEXT:
                begin
                    if (total_reg == '0)
                    begin
                        out_data_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        out_data_next.picked_id = pick_chain[QUEUE_DEPTH];
                        if (CNT_W'(cursor_inc) >= total_reg)
                        begin
                            cursor_next = '0;
                        end
                        else
                        begin
                            cursor_next = cursor_inc[IDX_W-1:0];
                        end
                    end
                end
                default:
                begin
                    out_data_next.status = ST_OK;
                end
            endcase
            out_data_next.occupancy = 5'(total_next);
            out_valid_next          = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold queue control state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            cursor_reg    <= cursor_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // Checks
    `RRQ_ASSERT_IMP(a_cursor_in_range, total_reg != '0, {1'b0, cursor_reg} < total_reg, "cursor past tail")
    `RRQ_ASSERT_IMP(a_cursor_home_empty, total_reg == '0, cursor_reg == '0, "cursor not home when empty")
    `RRQ_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= CNT_W'(QUEUE_DEPTH), "fill count overflow")
    `RRQ_ASSERT_IMP(a_full_status, out_valid_reg && out_data_reg.status == ST_FULL, out_data_reg.occupancy == 5'(QUEUE_DEPTH), "full status below depth")
    `RRQ_ASSERT_NXT(a_enq_grows, ctl.enq_wr, total_reg == $past(total_reg) + CNT_W'(1), "enqueue did not grow queue")

endmodule
